// ----- rtl/core/ordered_sparse_accumulator_defines.svh -----
// Assertion macros shared by the ordered sparse accumulator RTL
`ifndef ORDERED_SPARSE_ACCUMULATOR_DEFINES_SVH
`define ORDERED_SPARSE_ACCUMULATOR_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define OSA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("osa assertion failed");

// next-cycle implication
`define OSA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("osa assertion failed");

`else

`define OSA_ASSERT_NOW(label, clk, rst, ante, cons)
`define OSA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/core/osa_pkg.sv -----
// Types, constants and arithmetic helpers of the ordered sparse accumulator
package osa_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
   localparam int KEY_W       = 32;
   localparam int AMT_W       = 32;
   localparam int ENTRY_W     = KEY_W + AMT_W;
   localparam int PADDR_W     = 4;
   localparam int PDATA_W     = 32;
   localparam int USER_W      = 2;

   localparam logic [CNT_W-1:0] DEPTH_COUNT = CNT_W'(TABLE_DEPTH);

   // register index, taken from paddr[3:2]
   localparam logic [1:0] REG_IDENTITY_KEY     = 2'd0;
   localparam logic [1:0] REG_FILTER_THRESHOLD = 2'd1;
   localparam logic [1:0] REG_FILTER_MODE      = 2'd2;

   // bit positions in rsp_tuser
   localparam int USER_EMPTY    = 0;
   localparam int USER_OVERFLOW = 1;

   typedef enum logic [1:0] {
      FILTER_NONE     = 2'd0,
      FILTER_AT_LEAST = 2'd1,
      FILTER_AT_MOST  = 2'd2,
      FILTER_POSITIVE = 2'd3
   } filter_mode_type;

   typedef struct packed {
      logic [KEY_W-1:0]        identity_key;
      logic signed [AMT_W-1:0] filter_threshold;
      filter_mode_type         filter_mode;
   } cfg_type;

   // signed add, clamped to the 32-bit range
   function automatic logic signed [AMT_W-1:0] sat_add(logic signed [AMT_W-1:0] a,
                                                       logic signed [AMT_W-1:0] b);
      logic signed [AMT_W:0] sum;
      sum = {a[AMT_W-1], a} + {b[AMT_W-1], b};
      if (sum[AMT_W] != sum[AMT_W-1]) begin
         return sum[AMT_W] ? {1'b1, {(AMT_W-1){1'b0}}} : {1'b0, {(AMT_W-1){1'b1}}};
      end
      return sum[AMT_W-1:0];
   endfunction

   function automatic logic passes(logic signed [AMT_W-1:0] v, cfg_type cfg);
      logic keep;
      case (cfg.filter_mode)
         FILTER_AT_LEAST: keep = (v >= cfg.filter_threshold);
         FILTER_AT_MOST:  keep = (v <= cfg.filter_threshold);
         FILTER_POSITIVE: keep = (v > 0);
         default:         keep = 1'b1;
      endcase
      return keep;
   endfunction

endpackage

// ----- rtl/core/osa_ram.sv -----
// Generic single-write, single-read RAM with registered read data
module osa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/core/osa_csr.sv -----
// APB-style configuration registers of the ordered sparse accumulator
module osa_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [osa_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [osa_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic [osa_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                         csr_pready,
   output osa_pkg::cfg_type             cfg
);

   osa_pkg::cfg_type cfg_ff;
   osa_pkg::cfg_type cfg_in;
   logic             wr_fire;
   logic [1:0]       reg_sel;

   assign csr_pready = 1'b1;
   assign wr_fire    = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign reg_sel    = csr_paddr[3:2];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_fire) begin
         case (reg_sel)
            osa_pkg::REG_IDENTITY_KEY:     cfg_in.identity_key = csr_pwdata;
            osa_pkg::REG_FILTER_THRESHOLD: cfg_in.filter_threshold = csr_pwdata;
            osa_pkg::REG_FILTER_MODE:
               cfg_in.filter_mode = osa_pkg::filter_mode_type'(csr_pwdata[1:0]);
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{identity_key: '0, filter_threshold: '0,
                     filter_mode: osa_pkg::FILTER_NONE};
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   always_comb begin
      case (reg_sel)
         osa_pkg::REG_IDENTITY_KEY:     csr_prdata = cfg_ff.identity_key;
         osa_pkg::REG_FILTER_THRESHOLD: csr_prdata = cfg_ff.filter_threshold;
         osa_pkg::REG_FILTER_MODE:
            csr_prdata = {{(osa_pkg::PDATA_W-2){1'b0}}, cfg_ff.filter_mode};
         default:                       csr_prdata = '0;
      endcase
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/core/ordered_sparse_accumulator.sv -----
// Top level of the ordered sparse accumulator: key table walker and result emitter
//
//   channel  | direction | transaction
//   req_*    | in        | one keyed amount, tlast marks the run's last item
//   rsp_*    | out       | one emitted entry, tlast on the run's last result
//   csr_*    | in/out    | APB-style register access, always ready
//
// An identity-key item is not stored; any other is accepted, compared with the held
// entries one at a time in the scan until a hit, as the table memory has a single read
// port, and then written back. Emission reads and checks each held entry, then ends the run.
// No clearing after reset: entries at or beyond the count are never read.
// Items wait during a scan or an emission; a stalled result stalls only the emission.
`include "ordered_sparse_accumulator_defines.svh"

module ordered_sparse_accumulator (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_tvalid,
   output logic                         req_tready,
   input  logic [63:0]                  req_tdata,   // key[31:0], amount[63:32]
   input  logic                         req_tlast,   // final_item
   output logic                         rsp_tvalid,
   input  logic                         rsp_tready,
   output logic [63:0]                  rsp_tdata,   // out_key[31:0], out_amount[63:32]
   output logic                         rsp_tlast,   // end_of_run
   output logic [osa_pkg::USER_W-1:0]   rsp_tuser,   // empty_result[0], overflow_seen[1]
   input  logic                         csr_psel,
   input  logic                         csr_penable,
   input  logic                         csr_pwrite,
   input  logic [osa_pkg::PADDR_W-1:0]  csr_paddr,
   input  logic [osa_pkg::PDATA_W-1:0]  csr_pwdata,
   output logic [osa_pkg::PDATA_W-1:0]  csr_prdata,
   output logic                         csr_pready
);

   typedef enum logic [6:0] {
      ST_IDLE      = 7'b0000001,
      ST_SCAN      = 7'b0000010,
      ST_UPDATE    = 7'b0000100,
      ST_APPEND    = 7'b0001000,
      ST_EMIT_RD   = 7'b0010000,
      ST_EMIT_CHK  = 7'b0100000,
      ST_EMIT_LAST = 7'b1000000
   } state_type;

   osa_pkg::cfg_type cfg;

   state_type                          state_ff, state_in;
   logic [osa_pkg::CNT_W-1:0]          idx_ff, idx_in;
   logic [osa_pkg::CNT_W-1:0]          count_ff, count_in;
   logic                               dropped_ff, dropped_in;
   logic [osa_pkg::KEY_W-1:0]          key_ff, key_in;
   logic signed [osa_pkg::AMT_W-1:0]   amount_ff, amount_in;
   logic                               final_ff, final_in;
   logic                               held_valid_ff, held_valid_in;
   logic [osa_pkg::KEY_W-1:0]          held_key_ff, held_key_in;
   logic signed [osa_pkg::AMT_W-1:0]   held_amount_ff, held_amount_in;

   logic                               rsp_valid_ff, rsp_valid_in;
   logic [osa_pkg::KEY_W-1:0]          rsp_key_ff, rsp_key_in;
   logic signed [osa_pkg::AMT_W-1:0]   rsp_amount_ff, rsp_amount_in;
   logic                               rsp_last_ff, rsp_last_in;
   logic                               rsp_empty_ff, rsp_empty_in;
   logic                               rsp_over_ff, rsp_over_in;
   logic                               rsp_load;
   logic                               rsp_free;

   logic                               ram_wr_en;
   logic [osa_pkg::IDX_W-1:0]          ram_wr_addr;
   logic [osa_pkg::ENTRY_W-1:0]        ram_wr_data;
   logic                               ram_rd_en;
   logic [osa_pkg::IDX_W-1:0]          ram_rd_addr;
   logic [osa_pkg::ENTRY_W-1:0]        ram_rd_data;
   logic [osa_pkg::KEY_W-1:0]          rd_key;
   logic signed [osa_pkg::AMT_W-1:0]   rd_amount;

   logic                               req_fire;
   logic [osa_pkg::CNT_W-1:0]          idx_inc;
   logic [osa_pkg::CNT_W-1:0]          last_idx;

   osa_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // entry layout: amount in the upper half, key in the lower half
   osa_ram #(
      .WIDTH (osa_pkg::ENTRY_W),
      .DEPTH (osa_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign rd_key    = ram_rd_data[osa_pkg::KEY_W-1:0];
   assign rd_amount = ram_rd_data[osa_pkg::ENTRY_W-1:osa_pkg::KEY_W];

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign idx_inc    = idx_ff + osa_pkg::CNT_W'(1);
   assign last_idx   = count_ff - osa_pkg::CNT_W'(1);

   always_comb begin
      state_in       = state_ff;
      idx_in         = idx_ff;
      count_in       = count_ff;
      dropped_in     = dropped_ff;
      key_in         = key_ff;
      amount_in      = amount_ff;
      final_in       = final_ff;
      held_valid_in  = held_valid_ff;
      held_key_in    = held_key_ff;
      held_amount_in = held_amount_ff;

      ram_wr_en   = 1'b0;
      ram_wr_addr = idx_ff[osa_pkg::IDX_W-1:0];
      ram_wr_data = {amount_ff, key_ff};
      ram_rd_en   = 1'b0;
      ram_rd_addr = idx_ff[osa_pkg::IDX_W-1:0];

      rsp_load      = 1'b0;
      rsp_key_in    = held_key_ff;
      rsp_amount_in = held_amount_ff;
      rsp_last_in   = 1'b0;
      rsp_empty_in  = 1'b0;
      rsp_over_in   = dropped_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               key_in    = req_tdata[osa_pkg::KEY_W-1:0];
               amount_in = req_tdata[osa_pkg::ENTRY_W-1:osa_pkg::KEY_W];
               final_in  = req_tlast;
               idx_in    = '0;
               if (req_tdata[osa_pkg::KEY_W-1:0] == cfg.identity_key) begin
                  state_in = req_tlast ? ST_EMIT_RD : ST_IDLE;
               end else if (count_ff == '0) begin
                  state_in = ST_APPEND;
               end else begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = '0;
                  state_in    = ST_SCAN;
               end
            end
         end
         ST_SCAN: begin
            // hold the read data on a hit so the update sees the stored amount
            if (rd_key == key_ff) begin
               state_in = ST_UPDATE;
            end else if (idx_ff == last_idx) begin
               state_in = ST_APPEND;
            end else begin
               idx_in      = idx_inc;
               ram_rd_en   = 1'b1;
               ram_rd_addr = idx_inc[osa_pkg::IDX_W-1:0];
            end
         end
         ST_UPDATE: begin
            ram_wr_en   = 1'b1;
            ram_wr_data = {osa_pkg::sat_add(rd_amount, amount_ff), key_ff};
            idx_in      = '0;
            state_in    = final_ff ? ST_EMIT_RD : ST_IDLE;
         end
         ST_APPEND: begin
            if (count_ff != osa_pkg::DEPTH_COUNT) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = count_ff[osa_pkg::IDX_W-1:0];
               count_in    = count_ff + osa_pkg::CNT_W'(1);
            end else begin
               dropped_in = 1'b1;
            end
            idx_in   = '0;
            state_in = final_ff ? ST_EMIT_RD : ST_IDLE;
         end
         ST_EMIT_RD: begin
            if (idx_ff == count_ff) begin
               state_in = ST_EMIT_LAST;
            end else begin
               ram_rd_en = 1'b1;
               state_in  = ST_EMIT_CHK;
            end
         end
         ST_EMIT_CHK: begin
            // keep one survivor back until the next one shows whether it ends the run
            if (!osa_pkg::passes(rd_amount, cfg)) begin
               idx_in   = idx_inc;
               state_in = ST_EMIT_RD;
            end else if (!held_valid_ff || rsp_free) begin
               rsp_load       = held_valid_ff;
               held_valid_in  = 1'b1;
               held_key_in    = rd_key;
               held_amount_in = rd_amount;
               idx_in         = idx_inc;
               state_in       = ST_EMIT_RD;
            end
         end
         ST_EMIT_LAST: begin
            if (rsp_free) begin
               rsp_load    = 1'b1;
               rsp_last_in = 1'b1;
               if (!held_valid_ff) begin
                  rsp_key_in    = '0;
                  rsp_amount_in = '0;
                  rsp_empty_in  = 1'b1;
               end
               held_valid_in = 1'b0;
               count_in      = '0;
               dropped_in    = 1'b0;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         count_ff      <= '0;
         dropped_ff    <= 1'b0;
         held_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         count_ff      <= count_in;
         dropped_ff    <= dropped_in;
         held_valid_ff <= held_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff         <= key_in;
      amount_ff      <= amount_in;
      final_ff       <= final_in;
      held_key_ff    <= held_key_in;
      held_amount_ff <= held_amount_in;
      if (rsp_load) begin
         rsp_key_ff    <= rsp_key_in;
         rsp_amount_ff <= rsp_amount_in;
         rsp_last_ff   <= rsp_last_in;
         rsp_empty_ff  <= rsp_empty_in;
         rsp_over_ff   <= rsp_over_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_amount_ff, rsp_key_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = {rsp_over_ff, rsp_empty_ff};

   `OSA_ASSERT_NOW(a_count_bound, clock, reset, 1'b1, count_ff <= osa_pkg::DEPTH_COUNT)
   `OSA_ASSERT_NOW(a_drop_only_full, clock, reset, dropped_ff, count_ff == osa_pkg::DEPTH_COUNT)
   `OSA_ASSERT_NOW(a_empty_ends_run, clock, reset, rsp_tvalid && rsp_tuser[osa_pkg::USER_EMPTY], rsp_tlast)
   `OSA_ASSERT_NEXT(a_clear_after_run, clock, reset, (state_ff == ST_EMIT_LAST) && rsp_free, (count_ff == '0) && !dropped_ff && !held_valid_ff)

endmodule
